### hw/rtl/heading_pid_controller_core_macros.svh
// Assertion helpers for the checker file of the heading controller.
`ifndef HEADING_PID_CONTROLLER_CORE_MACROS_SVH
`define HEADING_PID_CONTROLLER_CORE_MACROS_SVH

// Property checked on every rising clock edge, reset included.
`define HPID_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

// Property checked on every rising clock edge while reset is low.
`define HPID_ASSERT_RUN(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

### hw/rtl/hpid_pkg.sv
package hpid_pkg;

   // Angle and gain formats.
   localparam int ANGLE_BITS     = 16;
   localparam int GAIN_FRAC_BITS = 16;
   localparam int GAIN_W         = 24;
   localparam int SUM_W          = 32;
   localparam int DRIVE_W        = 16;
   localparam int MODE_W         = 2;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   // Derived datapath widths.
   localparam int DIFF_W    = ANGLE_BITS + 1;
   localparam int ISUM_W    = SUM_W + 2;
   localparam int PROD_P_W  = ANGLE_BITS + GAIN_W;
   localparam int PROD_D_W  = DIFF_W + GAIN_W;
   localparam int PROD_I_W  = SUM_W + GAIN_W;
   localparam int ACC_W     = PROD_I_W + 1;
   localparam int DIV_SHIFT = GAIN_FRAC_BITS + 1;
   localparam int QUOT_W    = ACC_W - DIV_SHIFT;

   // Added to a negative sum before the shift so that it truncates toward zero.
   localparam logic [ACC_W-1:0] DIV_BIAS = {{(ACC_W - DIV_SHIFT){1'b0}}, {DIV_SHIFT{1'b1}}};

   localparam logic [MODE_W-1:0] MODE_P   = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_PD  = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_PID = MODE_W'(2);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MODE  = CSR_ADDR_W'(0),
      CSR_FRONT = CSR_ADDR_W'(1),
      CSR_KP    = CSR_ADDR_W'(2),
      CSR_KI    = CSR_ADDR_W'(3),
      CSR_KD    = CSR_ADDR_W'(4)
   } csr_index_type;

   typedef struct packed {
      logic [MODE_W-1:0]            mode;
      logic [ANGLE_BITS-1:0]        front_heading;
      logic signed [GAIN_W-1:0]     kp;
      logic signed [GAIN_W-1:0]     ki;
      logic signed [GAIN_W-1:0]     kd;
   } cfg_type;

   typedef struct packed {
      logic                         action;
      logic [ANGLE_BITS-1:0]        heading;
      logic signed [ANGLE_BITS-1:0] target;
   } req_type;

   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] err;
      logic signed [DIFF_W-1:0]     diff;
      logic signed [SUM_W-1:0]      isum;
      logic                         clip;
   } err_stage_type;

   typedef struct packed {
      logic signed [PROD_P_W-1:0]   prod_p;
      logic signed [PROD_D_W-1:0]   prod_d;
      logic signed [PROD_I_W-1:0]   prod_i;
      logic                         clip;
   } prod_stage_type;

   typedef struct packed {
      logic signed [ACC_W-1:0]      acc;
      logic                         clip;
   } acc_stage_type;

endpackage

### hw/rtl/hpid_err.sv
// Input register, heading error, and the integral/previous-error state.
module hpid_err
   import hpid_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_word,
   output logic          err_valid,
   input  logic          err_ready,
   output err_stage_type err_word
);

   logic                         a_valid_ff, a_valid_in;
   req_type                      a_word_ff, a_word_in;
   logic                         b_valid_ff, b_valid_in;
   err_stage_type                b_word_ff, b_word_in;
   logic signed [SUM_W-1:0]      error_sum_ff, error_sum_in;
   logic signed [ANGLE_BITS-1:0] last_error_ff, last_error_in;

   logic                         a_ready, b_ready, a_move;
   logic signed [ANGLE_BITS-1:0] err;
   logic signed [ISUM_W-1:0]     isum_raw;
   logic signed [SUM_W-1:0]      isum_sat;
   logic                         isum_ovf, use_d, use_i;

   assign b_ready   = !b_valid_ff || err_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign a_move    = a_valid_ff && b_ready;
   assign req_ready = a_ready;
   assign err_valid = b_valid_ff;
   assign err_word  = b_word_ff;

   always_comb begin
      // Modulo a full turn, read as two's complement: the wrap to a signed half turn.
      err = ANGLE_BITS'(a_word_ff.heading - a_word_ff.target - cfg.front_heading);
      isum_raw = ISUM_W'(error_sum_ff) + ISUM_W'(err) + ISUM_W'(last_error_ff);
      isum_ovf = (isum_raw[ISUM_W-1:SUM_W-1] != '0) && (isum_raw[ISUM_W-1:SUM_W-1] != '1);
      if (isum_ovf) begin
         isum_sat = isum_raw[ISUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         isum_sat = isum_raw[SUM_W-1:0];
      end
      use_d = cfg.mode != MODE_P;
      use_i = cfg.mode >= MODE_PID;

      a_valid_in    = a_ready ? req_valid : a_valid_ff;
      a_word_in     = (a_ready && req_valid) ? req_word : a_word_ff;
      b_valid_in    = b_ready ? a_valid_ff : b_valid_ff;
      b_word_in     = b_word_ff;
      error_sum_in  = error_sum_ff;
      last_error_in = last_error_ff;

      if (a_move) begin
         if (a_word_ff.action) begin
            error_sum_in  = '0;
            last_error_in = '0;
            b_word_in     = '0;
         end else begin
            last_error_in = err;
            if (use_i) begin
               error_sum_in = isum_sat;
            end
            b_word_in.err  = err;
            b_word_in.diff = use_d ? DIFF_W'(err) - DIFF_W'(last_error_ff) : '0;
            b_word_in.isum = use_i ? isum_sat : '0;
            b_word_in.clip = use_i && isum_ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else begin
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
         error_sum_ff  <= error_sum_in;
         last_error_ff <= last_error_in;
      end
   end

   always_ff @(posedge clock) begin
      a_word_ff <= a_word_in;
      b_word_ff <= b_word_in;
   end

endmodule

### hw/rtl/hpid_mac.sv
// Gain products in one stage, their sum in the next.
module hpid_mac
   import hpid_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          err_valid,
   output logic          err_ready,
   input  err_stage_type err_word,
   output logic          acc_valid,
   input  logic          acc_ready,
   output acc_stage_type acc_word
);

   logic           c_valid_ff, c_valid_in;
   prod_stage_type c_word_ff, c_word_in;
   logic           d_valid_ff, d_valid_in;
   acc_stage_type  d_word_ff, d_word_in;
   logic           c_ready, d_ready;

   assign d_ready   = !d_valid_ff || acc_ready;
   assign c_ready   = !c_valid_ff || d_ready;
   assign err_ready = c_ready;
   assign acc_valid = d_valid_ff;
   assign acc_word  = d_word_ff;

   always_comb begin
      c_valid_in = c_ready ? err_valid : c_valid_ff;
      c_word_in  = c_word_ff;
      if (c_ready && err_valid) begin
         c_word_in.prod_p = PROD_P_W'($signed(err_word.err)) * PROD_P_W'($signed(cfg.kp));
         c_word_in.prod_d = PROD_D_W'($signed(err_word.diff)) * PROD_D_W'($signed(cfg.kd));
         c_word_in.prod_i = PROD_I_W'($signed(err_word.isum)) * PROD_I_W'($signed(cfg.ki));
         c_word_in.clip   = err_word.clip;
      end

      d_valid_in = d_ready ? c_valid_ff : d_valid_ff;
      d_word_in  = d_word_ff;
      if (d_ready && c_valid_ff) begin
         // P and D products count twice: the trapezoid halving sits in the final shift.
         d_word_in.acc  = (ACC_W'($signed(c_word_ff.prod_p)) <<< 1)
                        + (ACC_W'($signed(c_word_ff.prod_d)) <<< 1)
                        + ACC_W'($signed(c_word_ff.prod_i));
         d_word_in.clip = c_word_ff.clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_word_ff <= c_word_in;
      d_word_ff <= d_word_in;
   end

endmodule

### hw/rtl/hpid_out.sv
// Scaling toward zero, drive saturation and the result register.
module hpid_out
   import hpid_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      acc_valid,
   output logic                      acc_ready,
   input  acc_stage_type             acc_word,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [DRIVE_W-1:0] rsp_drive,
   output logic                      rsp_clipped
);

   logic                      valid_ff, valid_in;
   logic signed [DRIVE_W-1:0] drive_ff, drive_in;
   logic                      clipped_ff, clipped_in;
   logic [ACC_W-1:0]          biased;
   logic [QUOT_W-1:0]         quot;
   logic                      quot_ovf, load;

   assign acc_ready   = !valid_ff || rsp_ready;
   assign load        = acc_ready && acc_valid;
   assign rsp_valid   = valid_ff;
   assign rsp_drive   = drive_ff;
   assign rsp_clipped = clipped_ff;

   always_comb begin
      biased   = acc_word.acc + (acc_word.acc[ACC_W-1] ? DIV_BIAS : '0);
      quot     = biased[ACC_W-1:DIV_SHIFT];
      quot_ovf = (quot[QUOT_W-1:DRIVE_W-1] != '0) && (quot[QUOT_W-1:DRIVE_W-1] != '1);

      valid_in   = acc_ready ? acc_valid : valid_ff;
      drive_in   = drive_ff;
      clipped_in = clipped_ff;
      if (load) begin
         if (quot_ovf) begin
            drive_in = quot[QUOT_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                                      : {1'b0, {(DRIVE_W-1){1'b1}}};
         end else begin
            drive_in = quot[DRIVE_W-1:0];
         end
         clipped_in = quot_ovf || acc_word.clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drive_ff   <= drive_in;
      clipped_ff <= clipped_in;
   end

endmodule

### hw/rtl/heading_pid_controller_core.sv
// Heading PID controller. Each request word carries a measured heading and a
// target offset as binary angles (a full turn is 65536 counts) plus an action
// flag; each one produces exactly one response word with the drive value and a
// clipped flag, in order. A word of action 1 clears the integral and the
// previous error and answers with drive 0. The error is heading minus target
// minus front_heading, wrapped to a signed half turn, and feeds P, PD or PID
// control as the mode register selects (mode 3 acts as PID). The block takes
// one word per clock cycle when the response side keeps up. The input register
// loads at the accepting edge; the error and integral update, the gain
// products, the product sum, and the drive scaling then each load a register
// of their own, the last being the response register. The integral and the
// previous error live in the second stage and are updated in the order words
// pass through it. The five register stages hold up to five words and fill
// bubbles independently, so the block keeps accepting while a response waits
// to be taken until every stage is full; only then does it push back on the
// request side. The user must see that registers are written through the csr
// port only while no word is in flight; the block does not enforce this.
// Writes to indexes past kd are ignored.
module heading_pid_controller_core
   import hpid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,    // [15:0] heading, [31:16] target
   input  logic                  req_tuser,    // [0] action

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,    // [15:0] drive
   output logic                  rsp_tuser,    // [0] clipped

   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_MODE:  cfg_in.mode          = csr_wdata[MODE_W-1:0];
            CSR_FRONT: cfg_in.front_heading = csr_wdata[ANGLE_BITS-1:0];
            CSR_KP:    cfg_in.kp            = csr_wdata[GAIN_W-1:0];
            CSR_KI:    cfg_in.ki            = csr_wdata[GAIN_W-1:0];
            CSR_KD:    cfg_in.kd            = csr_wdata[GAIN_W-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode          <= MODE_PID;
         cfg_ff.front_heading <= '0;
         cfg_ff.kp            <= '0;
         cfg_ff.ki            <= '0;
         cfg_ff.kd            <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request word unpacking.
   req_type req_word;

   assign req_word.action  = req_tuser;
   assign req_word.heading = req_tdata[ANGLE_BITS-1:0];
   assign req_word.target  = req_tdata[2*ANGLE_BITS-1:ANGLE_BITS];

   logic          err_valid, err_ready;
   err_stage_type err_word;
   logic          acc_valid, acc_ready;
   acc_stage_type acc_word;

   hpid_err u_err (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_word  (req_word),
      .err_valid (err_valid),
      .err_ready (err_ready),
      .err_word  (err_word)
   );

   hpid_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .err_valid (err_valid),
      .err_ready (err_ready),
      .err_word  (err_word),
      .acc_valid (acc_valid),
      .acc_ready (acc_ready),
      .acc_word  (acc_word)
   );

   hpid_out u_out (
      .clock       (clock),
      .reset       (reset),
      .acc_valid   (acc_valid),
      .acc_ready   (acc_ready),
      .acc_word    (acc_word),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_drive   (rsp_tdata),
      .rsp_clipped (rsp_tuser)
   );

endmodule

### hw/rtl/hpid_checker.sv
`include "heading_pid_controller_core_macros.svh"

// Port-level checks of the heading controller.
module hpid_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   // After reset the pipe is empty: ready at once, and no response can
   // come out before a word has crossed all five stages.
   `HPID_ASSERT_ALWAYS(a_reset_empty, reset |=> req_tready && !rsp_tvalid ##1 !rsp_tvalid ##1 !rsp_tvalid, "response too early after reset")

   // With the response register empty nothing downstream can hold the input back.
   `HPID_ASSERT_RUN(a_ready_when_drained, !rsp_tvalid |-> req_tready, "input stalled with empty response register")

   // A stalled response word holds its data.
   `HPID_ASSERT_RUN(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response word changed")

endmodule

bind heading_pid_controller_core hpid_checker u_hpid_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
